// ===== hw/rtl/ddvg_pkg.sv =====
// Package with shared types, constants and codes for the velocity governor.
`default_nettype none
package ddvg_pkg;

  localparam logic [15:0] TrackWidthReset = 16'd26411;
  localparam logic [23:0] DpcReset        = 24'd113414;
  localparam logic [7:0]  MaxFwdReset     = 8'd100;
  localparam logic [7:0]  MaxRevReset     = 8'd100;
  localparam logic [15:0] TimeoutReset    = 16'd1000;

  localparam logic [2:0] RegTrackWidth = 3'd0;
  localparam logic [2:0] RegDpc        = 3'd1;
  localparam logic [2:0] RegMaxFwd     = 3'd2;
  localparam logic [2:0] RegMaxRev     = 3'd3;
  localparam logic [2:0] RegTimeout    = 3'd4;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic [31:0]       now_ms;
    logic              safe_forward;
    logic              safe_backward;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
    logic               is_moving;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GUARD,
    ST_OFFMUL,
    ST_LIMMUL,
    ST_CLAMP,
    ST_LDIV_START,
    ST_LDIV_WAIT,
    ST_RDIV_START,
    ST_RDIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [41:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [41:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/diff_drive_velocity_governor_core.sv =====
// Top level of the differential-drive velocity governor.
//
//  channel  | valid     | ready     | payload
//  ---------+-----------+-----------+----------------------
//  input    | in_valid  | in_ready  | in_item  (in_item_t)
//  result   | out_valid | out_ready | out_item (out_item_t)
//  config   | cfg_valid | cfg_ready | cfg_item (cfg_item_t)
//
// Each item passes the accepting state, the guard, both multiplies and the clamp,
// two divider passes (start, 42 quotient steps, sign fix, done) and the state
// offering the result. Reset (synchronous, rst high) restores register defaults
// and clears held state. The input is not taken while an item is in work or its
// result waits, so a low out_ready holds back the input too.
`default_nettype none
module diff_drive_velocity_governor_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ddvg_pkg::in_item_t in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ddvg_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire ddvg_pkg::cfg_item_t cfg_item
);

  logic [15:0] wheel_base;
  logic [23:0] dpc_reg;
  logic [7:0]  max_fwd;
  logic [7:0]  max_rev;
  logic [15:0] timeout;

  logic signed [31:0] held_linear;
  logic signed [31:0] held_angular;
  logic [31:0]        last_command_time;
  logic               moving_flag;

  ddvg_pkg::state_t state, state_next;
  ddvg_pkg::in_item_t item;
  logic [32:0] absoff;
  logic [32:0] lim;
  logic signed [33:0] lin;
  logic signed [15:0] left_spd;
  ddvg_pkg::div_req_t dreq;
  ddvg_pkg::div_rsp_t drsp;

  logic [23:0] dpc;
  logic [47:0] offprod;
  logic [31:0] limprod;
  logic [31:0] absang;
  logic signed [31:0] lin_g;
  logic signed [31:0] ang_g;
  logic signed [33:0] lin_c;
  logic signed [34:0] wsum;
  logic signed [34:0] wmag;
  logic signed [15:0] sat_q;

  assign dpc    = (dpc_reg == 24'd0) ? 24'd1 : dpc_reg;
  assign absang = held_angular[31] ? -held_angular : held_angular;
  assign offprod = absang * wheel_base;
  assign limprod = (held_linear > 0 ? max_fwd : max_rev) * dpc;

  // Configuration writes.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base  <= ddvg_pkg::TrackWidthReset;
      dpc_reg     <= ddvg_pkg::DpcReset;
      max_fwd     <= ddvg_pkg::MaxFwdReset;
      max_rev     <= ddvg_pkg::MaxRevReset;
      timeout     <= ddvg_pkg::TimeoutReset;
    end else if (cfg_valid) begin
      case (cfg_item.index)
        ddvg_pkg::RegTrackWidth: wheel_base  <= cfg_item.data[15:0];
        ddvg_pkg::RegDpc:        dpc_reg     <= cfg_item.data[23:0];
        ddvg_pkg::RegMaxFwd:     max_fwd     <= cfg_item.data[7:0];
        ddvg_pkg::RegMaxRev:     max_rev     <= cfg_item.data[7:0];
        ddvg_pkg::RegTimeout:    timeout     <= cfg_item.data[15:0];
        default: ;
      endcase
    end
  end

  // Safety and watchdog guard on the held command.
  always_comb begin
    lin_g = held_linear;
    ang_g = held_angular;
    if ((held_linear > 0 && !item.safe_forward) ||
        (held_linear < 0 && !item.safe_backward)) begin
      lin_g = '0;
      ang_g = '0;
    end
    if (moving_flag && ((item.now_ms - last_command_time) > {16'd0, timeout})) begin
      lin_g = '0;
      ang_g = '0;
    end
  end

  // Clamp against the limit less the turn offset.
  always_comb begin
    lin_c = 34'(held_linear);
    if (held_linear > 0) begin
      if ($signed({1'b0, lim}) - $signed({1'b0, absoff}) < lin_c) begin
        lin_c = 34'($signed({1'b0, lim}) - $signed({1'b0, absoff}));
      end
    end else if (held_linear < 0) begin
      if ($signed({1'b0, absoff}) - $signed({1'b0, lim}) > lin_c) begin
        lin_c = 34'($signed({1'b0, absoff}) - $signed({1'b0, lim}));
      end
    end
  end

  // Divider request and saturation of its result.
  always_comb begin
    logic signed [34:0] offs;
    offs = held_angular[31] ? -$signed({2'b0, absoff}) : $signed({2'b0, absoff});
    wsum = (state == ddvg_pkg::ST_LDIV_START) ? 35'(lin) - offs : 35'(lin) + offs;
    wmag = wsum[34] ? -wsum : wsum;
    dreq.start    = (state == ddvg_pkg::ST_LDIV_START) || (state == ddvg_pkg::ST_RDIV_START);
    dreq.neg      = wsum[34];
    dreq.dividend = {wmag[33:0], 8'd0};
    dreq.divisor  = dpc;
    if ($signed(drsp.quotient) > 42'sd32767) sat_q = 16'sd32767;
    else if ($signed(drsp.quotient) < -42'sd32768) sat_q = -16'sd32768;
    else sat_q = drsp.quotient[15:0];
  end

  ddvg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ddvg_pkg::ST_IDLE:       if (in_valid) state_next = ddvg_pkg::ST_GUARD;
      ddvg_pkg::ST_GUARD:      state_next = ddvg_pkg::ST_OFFMUL;
      ddvg_pkg::ST_OFFMUL:     state_next = ddvg_pkg::ST_LIMMUL;
      ddvg_pkg::ST_LIMMUL:     state_next = ddvg_pkg::ST_CLAMP;
      ddvg_pkg::ST_CLAMP:      state_next = ddvg_pkg::ST_LDIV_START;
      ddvg_pkg::ST_LDIV_START: state_next = ddvg_pkg::ST_LDIV_WAIT;
      ddvg_pkg::ST_LDIV_WAIT:  if (drsp.done) state_next = ddvg_pkg::ST_RDIV_START;
      ddvg_pkg::ST_RDIV_START: state_next = ddvg_pkg::ST_RDIV_WAIT;
      ddvg_pkg::ST_RDIV_WAIT:  if (drsp.done) state_next = ddvg_pkg::ST_OUT;
      ddvg_pkg::ST_OUT:        if (out_ready) state_next = ddvg_pkg::ST_IDLE;
      default:                 state_next = ddvg_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state == ddvg_pkg::ST_IDLE);
    out_valid = (state == ddvg_pkg::ST_OUT);
  end

  // Datapath and held state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ddvg_pkg::ST_IDLE;
      held_linear       <= '0;
      held_angular      <= '0;
      last_command_time <= '0;
      moving_flag       <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ddvg_pkg::ST_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            if (in_item.req_type) begin
              held_linear       <= in_item.linear_cmd;
              held_angular      <= in_item.angular_cmd;
              last_command_time <= in_item.now_ms;
            end
          end
        end
        ddvg_pkg::ST_GUARD: begin
          held_linear  <= lin_g;
          held_angular <= ang_g;
        end
        ddvg_pkg::ST_OFFMUL: absoff <= 33'((offprod + 48'h10000) >> 17);
        ddvg_pkg::ST_LIMMUL: lim    <= 33'((limprod + 32'd128) >> 8);
        ddvg_pkg::ST_CLAMP: begin
          lin         <= lin_c;
          held_linear <= lin_c[31:0];
        end
        ddvg_pkg::ST_LDIV_WAIT: if (drsp.done) left_spd <= sat_q;
        ddvg_pkg::ST_RDIV_WAIT: begin
          if (drsp.done) begin
            out_item.left_wheel_speed  <= left_spd;
            out_item.right_wheel_speed <= sat_q;
            out_item.is_moving         <= (left_spd != 0) || (sat_q != 0);
            moving_flag                <= (left_spd != 0) || (sat_q != 0);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ddvg_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, signed result truncated to zero.
`default_nettype none
module ddvg_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ddvg_pkg::div_req_t req,
  output ddvg_pkg::div_rsp_t      rsp
);

  logic [41:0] quo;
  logic [23:0] rem;
  logic [23:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;

  logic [24:0] trial;
  logic [24:0] shifted;

  // One restoring step on the partial remainder.
  always_comb begin
    shifted = {rem, quo[41]};
    trial   = shifted - {1'b0, dvs};
  end

  // Sequencing of the 42 quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd42;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.neg;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            quo <= -quo;
          end
        end else begin
          cnt <= cnt - 6'd1;
          if (!trial[24]) begin
            rem <= trial[23:0];
            quo <= {quo[40:0], 1'b1};
          end else begin
            rem <= shifted[23:0];
            quo <= {quo[40:0], 1'b0};
          end
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

// ===== bench/ddvg_wheel_checker.sv =====
// Checker for the velocity governor: predicts wheel speeds and compares results.
module ddvg_wheel_checker
  import ddvg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_item,
  output int        mismatches,
  output int        speeds_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the configuration registers.
  logic [15:0] wheel_base;
  logic [23:0] count_dist;
  logic [7:0]  fwd_limit_counts;
  logic [7:0]  rev_limit_counts;
  logic [15:0] cmd_timeout;

  // Mirror of the held command and watchdog state.
  longint      hold_lin;
  longint      hold_ang;
  logic [31:0] cmd_stamp;
  bit          was_moving;

  out_item_t   speeds_due[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Works out one control pass and updates the mirrored state.
  function automatic out_item_t predict_wheels(input in_item_t it);
    out_item_t r;
    longint mag, absoff, off, dpc, lim, lin, lft, rgt;
    logic [31:0] since;
    if (it.req_type) begin
      hold_lin = longint'(it.linear_cmd);
      hold_ang = longint'(it.angular_cmd);
      cmd_stamp = it.now_ms;
    end
    // Unsafe direction drops the command.
    if ((hold_lin > 0 && !it.safe_forward) || (hold_lin < 0 && !it.safe_backward)) begin
      hold_lin = 0;
      hold_ang = 0;
    end
    // Watchdog only acts while moving.
    since = it.now_ms - cmd_stamp;
    if (was_moving && since > {16'd0, cmd_timeout}) begin
      hold_lin = 0;
      hold_ang = 0;
    end
    mag = hold_ang < 0 ? -hold_ang : hold_ang;
    absoff = (mag * longint'(wheel_base) + 64'h10000) >>> 17;
    off = hold_ang < 0 ? -absoff : absoff;
    dpc = count_dist == 0 ? 1 : longint'(count_dist);
    lin = hold_lin;
    // Clamp to the limit less the turn offset; may flip sign.
    if (lin > 0) begin
      lim = (longint'(fwd_limit_counts) * dpc + 128) >>> 8;
      if (lim - absoff < lin) lin = lim - absoff;
    end else if (lin < 0) begin
      lim = (longint'(rev_limit_counts) * dpc + 128) >>> 8;
      if (absoff - lim > lin) lin = absoff - lim;
    end
    hold_lin = lin;
    lft = clip16(((lin - off) * 256) / dpc);
    rgt = clip16(((lin + off) * 256) / dpc);
    was_moving = (lft != 0) || (rgt != 0);
    r.left_wheel_speed = lft[15:0];
    r.right_wheel_speed = rgt[15:0];
    r.is_moving = was_moving;
    return r;
  endfunction

  // Watch all three channels at each edge.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      mismatches = 0;
      wheel_base = TrackWidthReset;
      count_dist = DpcReset;
      fwd_limit_counts = MaxFwdReset;
      rev_limit_counts = MaxRevReset;
      cmd_timeout = TimeoutReset;
      hold_lin = 0;
      hold_ang = 0;
      cmd_stamp = '0;
      was_moving = 0;
      speeds_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (speeds_due.size() == 0) begin
          report_mismatch("result with no transaction pending", 0, 0);
        end else begin
          want = speeds_due.pop_front();
          if (out_item.left_wheel_speed !== want.left_wheel_speed)
            report_mismatch("left_wheel_speed", out_item.left_wheel_speed,
                            want.left_wheel_speed);
          if (out_item.right_wheel_speed !== want.right_wheel_speed)
            report_mismatch("right_wheel_speed", out_item.right_wheel_speed,
                            want.right_wheel_speed);
          if (out_item.is_moving !== want.is_moving)
            report_mismatch("is_moving", out_item.is_moving, want.is_moving);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_item.index)
          RegTrackWidth: wheel_base = cfg_item.data[15:0];
          RegDpc:        count_dist = cfg_item.data[23:0];
          RegMaxFwd:     fwd_limit_counts = cfg_item.data[7:0];
          RegMaxRev:     rev_limit_counts = cfg_item.data[7:0];
          RegTimeout:    cmd_timeout = cfg_item.data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) speeds_due.push_back(predict_wheels(in_item));
    end
    speeds_pending = speeds_due.size();
  end
endmodule

// ===== bench/tb_diff_drive_velocity_governor_core.sv =====
// Testbench top for the velocity governor: stimulus, configuration phases and verdict.
module tb_diff_drive_velocity_governor_core;
  import ddvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_item;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  cfg_item_t cfg_item = '0;
  int        mismatches;
  int        speeds_pending;

  // Stimulus knobs shared between processes.
  int          idle_pct = 28;
  bit          hold_off_req = 0;
  int          hold_off_cnt = 0;
  bit          hold_off_done = 0;
  logic [31:0] clock_ms = 32'd0;
  logic [15:0] cur_timeout = TimeoutReset;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  diff_drive_velocity_governor_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_item(cfg_item)
  );

  ddvg_wheel_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_item(cfg_item),
    .mismatches(mismatches), .speeds_pending(speeds_pending)
  );

  // Result side: random stalls, plus one hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_off_req && !hold_off_done) begin
      out_ready <= 0;
      if (hold_off_cnt == 1499) hold_off_done <= 1;
      hold_off_cnt <= hold_off_cnt + 1;
    end else begin
      out_ready <= $urandom_range(99) >= idle_pct;
    end
  end

  // Offers one pass and waits until it is taken.
  task automatic send_pass(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_item <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // Lets the block drain before registers change; the count is read away from the edge.
  task automatic wait_idle();
    in_valid <= 0;
    @(negedge clk);
    while (speeds_pending != 0) @(negedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic load_setting(input logic [15:0] tw, input logic [23:0] dpc,
                              input logic [7:0] fmax, input logic [7:0] rmax,
                              input logic [15:0] tmo);
    wait_idle();
    write_reg(RegTrackWidth, {16'($urandom), tw});
    write_reg(RegDpc, {8'($urandom), dpc});
    write_reg(RegMaxFwd, {24'($urandom), fmax});
    write_reg(RegMaxRev, {24'($urandom), rmax});
    write_reg(RegTimeout, {16'($urandom), tmo});
    cur_timeout = tmo;
  endtask

  function automatic in_item_t mk_pass(input bit cmd, input logic [31:0] lin,
                                       input logic [31:0] ang, input logic [31:0] t,
                                       input bit fwd, input bit rev);
    in_item_t it;
    it.req_type = cmd;
    it.linear_cmd = lin;
    it.angular_cmd = ang;
    it.now_ms = t;
    it.safe_forward = fwd;
    it.safe_backward = rev;
    return it;
  endfunction

  // Random velocity: mostly near the limits, sometimes anything.
  function automatic logic [31:0] rand_velocity();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(4096)) - 2048);
      default: return 32'($signed($urandom_range(262144)) - 131072);
    endcase
  endfunction

  // Random pass: clock advances around the watchdog period.
  function automatic in_item_t rand_pass();
    logic [31:0] step;
    case ($urandom_range(9))
      0: step = $urandom;
      1, 2: step = {16'd0, cur_timeout} + $urandom_range(2) - 1;
      default: step = $urandom_range(int'(cur_timeout) / 4 + 2);
    endcase
    clock_ms = clock_ms + step;
    return mk_pass(1'($urandom_range(1)), rand_velocity(), rand_velocity(), clock_ms,
                   $urandom_range(9) != 0, $urandom_range(9) != 0);
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_pass(rand_pass());
  endtask

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_setting(16'd26411, 24'd113414, 8'd100, 8'd100, 16'd1000);
    write_reg(3'd5, $urandom);
    write_reg(3'd7, $urandom);

    // Directed passes: extremes, unsafe directions, watchdog, sign flip, wrap.
    send_pass(mk_pass(1, 32'h7fffffff, 32'h7fffffff, 32'd0, 1, 1));
    send_pass(mk_pass(1, 32'h80000000, 32'h80000000, 32'd1, 1, 1));
    send_pass(mk_pass(1, 32'h80000000, 32'h7fffffff, 32'd2, 1, 1));
    send_pass(mk_pass(1, 32'h00010000, 32'h00000000, 32'd3, 0, 1));
    send_pass(mk_pass(1, 32'hffff0000, 32'h00000000, 32'd4, 1, 0));
    send_pass(mk_pass(1, 32'h00000000, 32'h00030000, 32'd5, 0, 0));
    send_pass(mk_pass(1, 32'h00008000, 32'h00000000, 32'd6, 1, 1));
    send_pass(mk_pass(0, 32'hffffffff, 32'hffffffff, 32'd1006, 1, 1));
    send_pass(mk_pass(0, 32'd0, 32'd0, 32'd1007, 1, 1));
    send_pass(mk_pass(1, 32'h00008000, 32'h00000000, 32'd2000, 1, 1));
    send_pass(mk_pass(0, 32'd0, 32'd0, 32'd3001, 1, 1));
    send_pass(mk_pass(1, 32'h00001000, 32'h00100000, 32'hfffffff0, 1, 1));
    send_pass(mk_pass(1, 32'hfffff000, 32'hfff00000, 32'hfffffffa, 1, 1));
    send_pass(mk_pass(0, 32'd0, 32'd0, 32'h00000100, 1, 1));
    send_pass(mk_pass(1, 32'h00000001, 32'hffffffff, 32'h00000101, 1, 1));

    load_setting(16'd0, 24'd0, 8'd0, 8'd0, 16'd0);
    send_pass(mk_pass(1, 32'h00000100, 32'h00010000, 32'd10, 1, 1));
    send_pass(mk_pass(1, 32'hffffff00, 32'h7fffffff, 32'd11, 1, 1));
    send_pass(mk_pass(0, 32'd0, 32'd0, 32'd12, 1, 1));
    clock_ms = 32'd12;
    run_random(150);

    load_setting(16'hffff, 24'hffffff, 8'hff, 8'hff, 16'hffff);
    send_pass(mk_pass(1, 32'h7fffffff, 32'h80000000, 32'd20, 1, 1));
    send_pass(mk_pass(1, 32'h80000000, 32'h80000000, 32'd21, 1, 1));
    send_pass(mk_pass(0, 32'd0, 32'd0, 32'd65556, 1, 1));
    clock_ms = 32'd65556;
    run_random(150);

    // Receiver holds off while passes keep coming.
    load_setting(16'd26411, 24'd113414, 8'd100, 8'd100, 16'd1000);
    hold_off_req = 1;
    run_random(200);

    // No idling on either side for a while.
    idle_pct = 0;
    run_random(200);
    idle_pct = 28;

    for (int ph = 0; ph < 3; ph++) begin
      load_setting(16'($urandom_range(65535)), 24'($urandom_range(200000)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   16'($urandom_range(3000)));
      run_random(200);
    end

    wait_idle();
    if (mismatches == 0)
      $display("diff_drive_velocity_governor_core: match");
    else
      $display("diff_drive_velocity_governor_core: mismatch");
    $finish;
  end

  initial begin
    #40ms;
    $display("diff_drive_velocity_governor_core: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/ddvg_pkg.sv
hw/rtl/ddvg_divider.sv
hw/rtl/diff_drive_velocity_governor_core.sv
bench/ddvg_wheel_checker.sv
bench/tb_diff_drive_velocity_governor_core.sv
